// ===== rtl/core/sprs_pkg.sv =====
// shared constants, codes and rail tables of the power rail sequencer
package sprs_pkg;

    localparam int TIMER_WIDTH_DEF = 16;

    localparam int RAIL_W   = 22;
    localparam int STATE_W  = 4;
    localparam int HOOK_W   = 3;
    localparam int WL_W     = 2;
    localparam int IN_W     = 8;
    localparam int OUT_W    = 40;
    localparam int CFG_IX_W = 2;
    localparam int CFG_W    = 16;

    localparam logic [RAIL_W-1:0] PIN_G3  = 22'h2FFC00;
    localparam int                RST_BIT = 21;

    typedef enum logic [1:0] {
        KIND_TICK      = 2'd0,
        KIND_BUTTON    = 2'd1,
        KIND_FORCE_OFF = 2'd2,
        KIND_WARM_RST  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_STEP_DELAY   = 2'd0,
        CFG_RESET_PULSE  = 2'd1,
        CFG_PGOOD_TMO    = 2'd2,
        CFG_USB_A_ON     = 2'd3
    } t_cfg_idx;

    localparam logic [HOOK_W-1:0] HOOK_NONE     = 3'd0;
    localparam logic [HOOK_W-1:0] HOOK_STARTUP  = 3'd1;
    localparam logic [HOOK_W-1:0] HOOK_RESUME   = 3'd2;
    localparam logic [HOOK_W-1:0] HOOK_SUSPEND  = 3'd3;
    localparam logic [HOOK_W-1:0] HOOK_SHUTDOWN = 3'd4;

    localparam logic [WL_W-1:0] WL_OFF     = 2'd0;
    localparam logic [WL_W-1:0] WL_ON      = 2'd1;
    localparam logic [WL_W-1:0] WL_SUSPEND = 2'd2;

    // last group index of each sequence and the reset pulse group of s3->s0
    localparam logic [2:0] UP_LAST    = 3'd6;
    localparam logic [2:0] ON_LAST    = 3'd5;
    localparam logic [2:0] PULSE_STEP = 3'd4;

    // bits switched on by group s; on_seq selects the s3->s0 table
    function automatic logic [RAIL_W-1:0] seq_set(input logic on_seq, input logic [2:0] s);
        logic [RAIL_W-1:0] v;
        v = '0;
        if (on_seq) begin
            case (s)
                3'd0:    v = 22'h000001;
                3'd5:    v = 22'h200000;
                default: v = '0;
            endcase
        end else begin
            case (s)
                3'd0:    v = 22'h000018;
                3'd1:    v = 22'h0003E0;
                3'd2:    v = 22'h000004;
                3'd4:    v = 22'h100002;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

    // bits switched off by group s
    function automatic logic [RAIL_W-1:0] seq_clr(input logic on_seq, input logic [2:0] s);
        logic [RAIL_W-1:0] v;
        v = '0;
        if (on_seq) begin
            case (s)
                3'd1:    v = 22'h008000;
                3'd2:    v = 22'h080000;
                3'd3:    v = 22'h040000;
                3'd4:    v = 22'h200000;
                3'd5:    v = 22'h000C00;
                default: v = '0;
            endcase
        end else begin
            case (s)
                3'd3:    v = 22'h007000;
                3'd5:    v = 22'h010000;
                3'd6:    v = 22'h020000;
                default: v = '0;
            endcase
        end
        return v;
    endfunction

endpackage

// ===== rtl/core/soc_power_rail_sequencer_unit.sv =====
// power rail sequencer: g3/s5/s3/s0 state machine driving 22 rail and reset pins
// an accepted input word passes the input register, then its result word the result register on the master side
// throughput: one word per cycle while the master side accepts, an input register feeds one pass of state logic
// into a result register, and the state registers close the loop in that same cycle
// reset (synchronous, active low): state g3, pins at g3 levels, registers at defaults,
// both pipeline stages empty
module soc_power_rail_sequencer_unit #(
    parameter int TIMER_WIDTH = sprs_pkg::TIMER_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration write port
    input  logic                          i_cfg_wr_en,
    input  logic [sprs_pkg::CFG_IX_W-1:0] i_cfg_index,
    input  logic [sprs_pkg::CFG_W-1:0]    i_cfg_data,
    // input words
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [0] pgood_sys, [1] pgood_pp5000, [2] pgood_ap, [3] susp_off, [7:4] zero
    input  logic [sprs_pkg::IN_W-1:0]     s_axis_tdata,
    // [1:0] kind
    input  logic [1:0]                    s_axis_tuser,
    // result words
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [21:0] rail_levels, [25:22] state code, [28:26] hook_event,
    // [30:29] wireless_mode, [31] deep_sleep_allowed, [32] usb_a_power,
    // [33] sequence_fault, [39:34] zero
    output logic [sprs_pkg::OUT_W-1:0]    m_axis_tdata
);
    import sprs_pkg::*;

    // compare width wide enough for both the timer and the 16 bit timeout
    localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

    typedef enum logic [STATE_W-1:0] {
        ST_G3   = 4'd0,
        ST_S5   = 4'd1,
        ST_S3   = 4'd2,
        ST_S0   = 4'd3,
        ST_G3S5 = 4'd4,
        ST_S5S3 = 4'd5,
        ST_S3S0 = 4'd6,
        ST_S0S3 = 4'd7,
        ST_S3S5 = 4'd8,
        ST_S5G3 = 4'd9
    } t_state;

    // configuration
    logic [7:0]  r_step_delay;
    logic [7:0]  r_reset_pulse;
    logic [15:0] r_pgood_tmo;
    logic        r_usb_a_on;

    // input stage
    logic       r_in_valid;
    t_kind      r_kind;
    logic [3:0] r_flags;

    // sequencer state
    t_state                 r_state,    n_state;
    logic                   r_pending,  n_pending;
    logic [3:0]             r_step,     n_step;
    logic [TIMER_WIDTH-1:0] r_timer,    n_timer;
    logic [RAIL_W-1:0]      r_pins,     n_pins;
    logic [WL_W-1:0]        r_wireless, n_wireless;
    logic                   r_usb_a,    n_usb_a;
    logic                   r_sleep_ok, n_sleep_ok;

    // result stage
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data, n_out_data;

    logic in_fire;
    logic advance;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // one pass of event handling then the current state's handler
    always_comb begin
        logic                   pg_sys, pg_5v, pg_ap, susp_off;
        logic                   good_s3, good_s0;
        logic                   rst_pulse, skip;
        logic                   on_seq, good, seq_ok, seq_fail;
        logic [2:0]             last, s;
        logic [7:0]             lim;
        logic [TIMER_WIDTH-1:0] t_inc;
        logic [HOOK_W-1:0]      hook;
        logic                   fault;
        logic [RAIL_W-1:0]      rails;

        pg_sys   = r_flags[0];
        pg_5v    = r_flags[1];
        pg_ap    = r_flags[2];
        susp_off = r_flags[3];
        good_s3  = pg_sys && pg_5v;
        good_s0  = good_s3 && pg_ap;

        n_state    = r_state;
        n_pending  = r_pending;
        n_step     = r_step;
        n_timer    = r_timer;
        n_pins     = r_pins;
        n_wireless = r_wireless;
        n_usb_a    = r_usb_a;
        n_sleep_ok = r_sleep_ok;
        rst_pulse  = 1'b0;
        skip       = 1'b0;
        hook       = HOOK_NONE;
        fault      = 1'b0;

        // an out-of-range code is taken as g3
        if (r_state > ST_S5G3) begin
            n_state = ST_G3;
            n_step  = '0;
            n_timer = '0;
        end

        case (r_kind)
            KIND_BUTTON: begin
                if (n_state == ST_G3) begin
                    n_state = ST_G3S5;
                    n_step  = '0;
                    n_timer = '0;
                    skip    = 1'b1;
                end else if (n_state != ST_S5 && n_state != ST_G3S5 &&
                             n_state != ST_S5G3) begin
                    n_pending = 1'b1;
                end
            end
            KIND_FORCE_OFF: n_pending = 1'b1;
            KIND_WARM_RST: begin
                rst_pulse       = 1'b1;
                n_pins[RST_BIT] = 1'b1;
            end
            default: ;
        endcase

        // shared rail sequence step, used by s5->s3 and s3->s0
        on_seq   = (n_state == ST_S3S0);
        last     = on_seq ? ON_LAST : UP_LAST;
        good     = on_seq ? good_s0 : good_s3;
        s        = (n_step > {1'b0, last}) ? last : n_step[2:0];
        seq_ok   = 1'b0;
        seq_fail = 1'b0;
        lim      = (on_seq && s == PULSE_STEP) ? r_reset_pulse : r_step_delay;
        if (lim == 8'd0) begin
            lim = 8'd1;
        end
        t_inc = (n_timer != '1) ? n_timer + 1'b1 : n_timer;

        if (!skip) begin
            unique case (n_state)
                ST_S5: begin
                    n_state = n_pending ? ST_S5G3 : ST_S5S3;
                    n_step  = '0;
                    n_timer = '0;
                end
                ST_S3: begin
                    if (!good_s3 || n_pending) begin
                        n_state = ST_S3S5;
                        n_step  = '0;
                        n_timer = '0;
                    end else if (susp_off) begin
                        n_state = ST_S3S0;
                        n_step  = '0;
                        n_timer = '0;
                    end
                end
                ST_S0: begin
                    if (!good_s0 || n_pending) begin
                        n_state = ST_S0S3;
                        n_step  = '0;
                        n_timer = '0;
                    end
                end
                ST_G3S5: begin
                    n_pending = 1'b0;
                    n_state   = ST_S5;
                    n_step    = '0;
                    n_timer   = '0;
                end
                ST_S5S3, ST_S3S0: begin
                    // group applied on the first tick of its step
                    if (n_timer == '0) begin
                        n_pins = (n_pins | seq_set(on_seq, s)) & ~seq_clr(on_seq, s);
                    end
                    if (s == last) begin
                        if (good) begin
                            seq_ok = 1'b1;
                        end else begin
                            n_timer = t_inc;
                            if (CW'(t_inc) >= CW'(r_pgood_tmo) || t_inc == '1) begin
                                seq_fail = 1'b1;
                            end
                        end
                    end else if (CW'(t_inc) >= CW'(lim)) begin
                        n_step  = {1'b0, s} + 4'd1;
                        n_timer = '0;
                    end else begin
                        n_timer = t_inc;
                    end
                    if (seq_ok) begin
                        n_step  = '0;
                        n_timer = '0;
                        if (on_seq) begin
                            n_wireless = WL_ON;
                            n_usb_a    = r_usb_a_on;
                            hook       = HOOK_RESUME;
                            n_sleep_ok = 1'b0;
                            n_state    = ST_S0;
                        end else begin
                            hook    = HOOK_STARTUP;
                            n_state = ST_S3;
                        end
                    end else if (seq_fail) begin
                        n_step    = '0;
                        n_timer   = '0;
                        n_pending = 1'b1;
                        fault     = 1'b1;
                        n_state   = on_seq ? ST_S3 : ST_S5;
                    end
                end
                ST_S0S3: begin
                    hook       = HOOK_SUSPEND;
                    n_wireless = WL_SUSPEND;
                    n_usb_a    = 1'b0;
                    n_sleep_ok = 1'b1;
                    n_state    = ST_S3;
                    n_step     = '0;
                    n_timer    = '0;
                end
                ST_S3S5: begin
                    hook       = HOOK_SHUTDOWN;
                    n_wireless = WL_OFF;
                    n_state    = ST_S5;
                    n_step     = '0;
                    n_timer    = '0;
                end
                ST_S5G3: begin
                    n_pins  = PIN_G3;
                    n_state = ST_G3;
                    n_step  = '0;
                    n_timer = '0;
                end
                default: ;
            endcase
        end

        // warm reset shows as a one-word low on the reset pin
        rails = n_pins;
        if (rst_pulse) begin
            rails[RST_BIT] = 1'b0;
        end

        n_out_data = {6'd0, fault, n_usb_a, n_sleep_ok, n_wireless, hook,
                      n_state, rails};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_delay  <= 8'd2;
            r_reset_pulse <= 8'd10;
            r_pgood_tmo   <= 16'd1000;
            r_usb_a_on    <= 1'b0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_state       <= ST_G3;
            r_pending     <= 1'b0;
            r_step        <= '0;
            r_timer       <= '0;
            r_pins        <= PIN_G3;
            r_wireless    <= WL_OFF;
            r_usb_a       <= 1'b0;
            r_sleep_ok    <= 1'b1;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_STEP_DELAY:  r_step_delay  <= i_cfg_data[7:0];
                    CFG_RESET_PULSE: r_reset_pulse <= i_cfg_data[7:0];
                    CFG_PGOOD_TMO:   r_pgood_tmo   <= i_cfg_data;
                    CFG_USB_A_ON:    r_usb_a_on    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // input stage
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            // result stage
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            // state moves once per word
            if (advance) begin
                r_state    <= n_state;
                r_pending  <= n_pending;
                r_step     <= n_step;
                r_timer    <= n_timer;
                r_pins     <= n_pins;
                r_wireless <= n_wireless;
                r_usb_a    <= n_usb_a;
                r_sleep_ok <= n_sleep_ok;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_kind  <= t_kind'(s_axis_tuser);
            r_flags <= s_axis_tdata[3:0];
        end
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

endmodule

// ===== sim/soc_power_rail_sequencer_unit_test.sv =====
// self-checking testbench of the power rail sequencer: directed start, bursts of random sequences
module soc_power_rail_sequencer_unit_test;

    import sprs_pkg::*;

    localparam int TMR_W = TIMER_WIDTH_DEF;
    localparam logic [TMR_W-1:0] TMR_SAT = {TMR_W{1'b1}};
    localparam int MAX_REPORTS = 40;

    // power states as the result word encodes them
    typedef enum logic [STATE_W-1:0] {
        PS_G3   = 4'd0,
        PS_S5   = 4'd1,
        PS_S3   = 4'd2,
        PS_S0   = 4'd3,
        PS_G3S5 = 4'd4,
        PS_S5S3 = 4'd5,
        PS_S3S0 = 4'd6,
        PS_S0S3 = 4'd7,
        PS_S3S5 = 4'd8,
        PS_S5G3 = 4'd9
    } t_pstate;

    // outcome of one tick of a rail sequence
    typedef enum logic [1:0] {
        SEQ_BUSY,
        SEQ_DONE,
        SEQ_TIMEOUT
    } t_seq_res;

    // one input word as the testbench keeps it
    typedef struct packed {
        logic [1:0] kind;
        logic       susp_off;
        logic       ap;
        logic       pp5;
        logic       sys;
    } sample_t;

    // one result word, laid out exactly as m_axis_tdata
    typedef struct packed {
        logic [5:0]        spare;
        logic              fault;
        logic              usb;
        logic              sleep;
        logic [WL_W-1:0]   wl;
        logic [HOOK_W-1:0] hook;
        logic [STATE_W-1:0] state;
        logic [RAIL_W-1:0] rails;
    } status_t;

    // ------------------------------------------------------------------
    // clock, reset and the block's inputs, all known from time zero
    // ------------------------------------------------------------------
    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_wr_en   = 1'b0;
    logic [CFG_IX_W-1:0] i_cfg_index   = '0;
    logic [CFG_W-1:0]    i_cfg_data    = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [IN_W-1:0]     s_axis_tdata  = '0;
    logic [1:0]          s_axis_tuser  = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [OUT_W-1:0]    m_axis_tdata;

    always #5 i_clk = ~i_clk;

    soc_power_rail_sequencer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [0] pgood_sys, [1] pgood_pp5000, [2] pgood_ap, [3] susp_off, [7:4] zero
        .s_axis_tdata  (s_axis_tdata),
        // [1:0] kind
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [21:0] rails, [25:22] state, [28:26] hook, [30:29] wireless,
        // [31] deep sleep, [32] usb-a, [33] fault, [39:34] zero
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------
    // word queues, pacing knobs and counters
    // ------------------------------------------------------------------
    sample_t pending_words_q[$];      // filled by the stimulus, drained by the driver
    status_t expected_status_q[$];    // predicted result words, oldest first

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;           // cycles the receiver still holds off

    int words_queued  = 0;
    int words_checked = 0;
    int mismatches    = 0;
    int resumes       = 0;
    int pgood_faults  = 0;
    int warm_resets   = 0;
    int settings_run  = 0;

    // ------------------------------------------------------------------
    // sequencer predictor: own copy of registers and state
    // ------------------------------------------------------------------
    logic [7:0]        step_dly_cfg  = 8'd2;
    logic [7:0]        rst_pulse_cfg = 8'd10;
    logic [15:0]       pgood_tmo_cfg = 16'd1000;
    logic              usb_a_cfg     = 1'b0;

    t_pstate           pwr_state   = PS_G3;
    logic              off_pending = 1'b0;
    logic [3:0]        seq_step    = '0;
    logic [TMR_W-1:0]  step_tmr    = '0;
    logic [RAIL_W-1:0] rail_pins   = PIN_G3;
    logic [WL_W-1:0]   wl_mode     = WL_OFF;
    logic              usb_a_on    = 1'b0;
    logic              sleep_ok    = 1'b1;

    // pins switched on by group s of the power-up (s5->s3) or resume (s3->s0) sequence
    function automatic logic [RAIL_W-1:0] group_on(input bit resume_seq, input int s);
        if (resume_seq)
            return (s == 0) ? 22'h000001 : (s == 5) ? 22'h200000 : '0;
        case (s)
            0:       return 22'h000018;   // logic and pp900 ap
            1:       return 22'h0003E0;   // the other pp900 rails
            2:       return 22'h000004;   // clogic
            4:       return 22'h100002;   // lpddr and pp5000
            default: return '0;
        endcase
    endfunction

    // active-low pins pulled low (rail on) or reset asserted by group s
    function automatic logic [RAIL_W-1:0] group_off(input bit resume_seq, input int s);
        if (resume_seq) begin
            case (s)
                1:       return 22'h008000;   // pp1800 s0
                2:       return 22'h080000;   // pp3300 s0
                3:       return 22'h040000;   // pp3300 usb
                4:       return 22'h200000;   // system reset held low
                5:       return 22'h000C00;   // lid and sensor
                default: return '0;
            endcase
        end
        case (s)
            3:       return 22'h007000;       // pp1800 pmu, avdd, usb
            5:       return 22'h010000;       // sixaxis
            6:       return 22'h020000;       // trackpad
            default: return '0;
        endcase
    endfunction

    function automatic void enter_state(input t_pstate s);
        pwr_state = s;
        seq_step  = '0;
        step_tmr  = '0;
    endfunction

    // saturating tick count
    function automatic void bump_timer();
        if (step_tmr != TMR_SAT)
            step_tmr = step_tmr + 1'b1;
    endfunction

    // one tick of a timed rail sequence; the last group doubles as the power-good wait
    function automatic t_seq_res run_group(input bit resume_seq, input bit good);
        int last;
        int s;
        int lim;
        last = resume_seq ? 5 : 6;
        s    = (seq_step > last) ? last : seq_step;
        if (step_tmr == 0)
            rail_pins = (rail_pins | group_on(resume_seq, s)) & ~group_off(resume_seq, s);
        if (s == last) begin
            if (good)
                return SEQ_DONE;
            bump_timer();
            if (step_tmr >= pgood_tmo_cfg || step_tmr == TMR_SAT)
                return SEQ_TIMEOUT;
            return SEQ_BUSY;
        end
        // the reset hold of the resume sequence has its own length
        lim = (resume_seq && s == 4) ? rst_pulse_cfg : step_dly_cfg;
        if (lim == 0)
            lim = 1;
        bump_timer();
        if (step_tmr >= lim) begin
            seq_step = 4'(s + 1);
            step_tmr = '0;
        end
        return SEQ_BUSY;
    endfunction

    // one tick: event first, then the handler of the current state
    function automatic status_t advance_sequencer(input sample_t w);
        status_t  r;
        logic     good_s3;
        logic     good_s0;
        logic     rst_now;
        logic     skip_fsm;
        t_seq_res sr;
        r        = '0;
        good_s3  = w.sys & w.pp5;
        good_s0  = good_s3 & w.ap;
        rst_now  = 1'b0;
        skip_fsm = 1'b0;

        case (w.kind)
            KIND_BUTTON: begin
                // a press wakes g3 straight away, is ignored around s5, else asks for shutdown
                if (pwr_state == PS_G3) begin
                    enter_state(PS_G3S5);
                    skip_fsm = 1'b1;
                end else if (pwr_state != PS_S5 && pwr_state != PS_G3S5 &&
                             pwr_state != PS_S5G3) begin
                    off_pending = 1'b1;
                end
            end
            KIND_FORCE_OFF: off_pending = 1'b1;
            KIND_WARM_RST: begin
                rst_now            = 1'b1;
                rail_pins[RST_BIT] = 1'b1;
                warm_resets++;
            end
            default: ;
        endcase

        if (!skip_fsm) begin
            case (pwr_state)
                PS_S5: enter_state(off_pending ? PS_S5G3 : PS_S5S3);
                PS_S3: begin
                    if (!good_s3 || off_pending)
                        enter_state(PS_S3S5);
                    else if (w.susp_off)
                        enter_state(PS_S3S0);
                end
                PS_S0: begin
                    if (!good_s0 || off_pending)
                        enter_state(PS_S0S3);
                end
                PS_G3S5: begin
                    off_pending = 1'b0;
                    enter_state(PS_S5);
                end
                PS_S5S3: begin
                    sr = run_group(1'b0, good_s3);
                    if (sr == SEQ_DONE) begin
                        r.hook = HOOK_STARTUP;
                        enter_state(PS_S3);
                    end else if (sr == SEQ_TIMEOUT) begin
                        off_pending = 1'b1;
                        r.fault     = 1'b1;
                        enter_state(PS_S5);
                    end
                end
                PS_S3S0: begin
                    sr = run_group(1'b1, good_s0);
                    if (sr == SEQ_DONE) begin
                        wl_mode  = WL_ON;
                        usb_a_on = usb_a_cfg;
                        sleep_ok = 1'b0;
                        r.hook   = HOOK_RESUME;
                        enter_state(PS_S0);
                    end else if (sr == SEQ_TIMEOUT) begin
                        off_pending = 1'b1;
                        r.fault     = 1'b1;
                        enter_state(PS_S3);
                    end
                end
                PS_S0S3: begin
                    // suspend leaves every rail as it is
                    r.hook   = HOOK_SUSPEND;
                    wl_mode  = WL_SUSPEND;
                    usb_a_on = 1'b0;
                    sleep_ok = 1'b1;
                    enter_state(PS_S3);
                end
                PS_S3S5: begin
                    r.hook  = HOOK_SHUTDOWN;
                    wl_mode = WL_OFF;
                    enter_state(PS_S5);
                end
                PS_S5G3: begin
                    rail_pins = PIN_G3;
                    enter_state(PS_G3);
                end
                default: ;
            endcase
        end

        r.rails = rail_pins;
        if (rst_now)
            r.rails[RST_BIT] = 1'b0;   // warm reset shows as a low reset pin on this tick
        r.state = pwr_state;
        r.wl    = wl_mode;
        r.sleep = sleep_ok;
        r.usb   = usb_a_on;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // driver: offers the front of the pending queue, predicts on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : drive_words
        sample_t w;
        status_t r;
        logic    offering;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            offering = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                w = pending_words_q.pop_front();
                r = advance_sequencer(w);
                expected_status_q.push_back(r);
                if (r.hook == HOOK_RESUME)
                    resumes++;
                if (r.fault)
                    pgood_faults++;
                offering = 1'b0;
            end
            // a word once offered stays up until taken
            if (!offering && pending_words_q.size() != 0 &&
                $urandom_range(99) >= send_idle_pct)
                offering = 1'b1;
            s_axis_tvalid <= offering;
            if (offering) begin
                w = pending_words_q[0];
                s_axis_tdata <= {4'b0000, w.susp_off, w.ap, w.pp5, w.sys};
                s_axis_tuser <= w.kind;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: random back-pressure, compares each result word in order
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < MAX_REPORTS)
            $display("mismatch at result word %0d: %s got 0x%0h want 0x%0h",
                     words_checked, field, got, want);
        mismatches++;
    endtask

    task automatic check_status(input status_t got);
        status_t want;
        if (expected_status_q.size() == 0) begin
            report_mismatch("unexpected word, state", got.state, '0);
            return;
        end
        want = expected_status_q.pop_front();
        if (got.rails !== want.rails) report_mismatch("rail_levels", got.rails, want.rails);
        if (got.state !== want.state) report_mismatch("state code", got.state, want.state);
        if (got.hook !== want.hook)   report_mismatch("hook_event", got.hook, want.hook);
        if (got.wl !== want.wl)       report_mismatch("wireless_mode", got.wl, want.wl);
        if (got.sleep !== want.sleep) report_mismatch("deep_sleep_allowed", got.sleep, want.sleep);
        if (got.usb !== want.usb)     report_mismatch("usb_a_power", got.usb, want.usb);
        if (got.fault !== want.fault) report_mismatch("sequence_fault", got.fault, want.fault);
        if (got.spare !== want.spare) report_mismatch("spare bits", got.spare, want.spare);
        words_checked++;
    endtask

    always @(posedge i_clk) begin : check_words
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready)
                check_status(m_axis_tdata);
            m_axis_tready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // long receiver hold-off, counted down here once the stimulus arms it
    always @(posedge i_clk) begin
        if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_word(input logic [1:0] kind, input bit sys, input bit pp5,
                             input bit ap, input bit susp);
        sample_t w;
        w.kind     = kind;
        w.sys      = sys;
        w.pp5      = pp5;
        w.ap       = ap;
        w.susp_off = susp;
        pending_words_q.push_back(w);
        words_queued++;
    endtask

    // plain tick with a little noise: the odd warm reset or power-good glitch
    task automatic push_tick(input bit sys, input bit pp5, input bit ap, input bit susp);
        logic [1:0] kind;
        int         roll;
        kind = KIND_TICK;
        roll = $urandom_range(99);
        if (roll < 3) begin
            kind = KIND_WARM_RST;
        end else if (roll < 6) begin
            case ($urandom_range(2))
                0:       sys = !sys;
                1:       pp5 = !pp5;
                default: ap  = !ap;
            endcase
        end
        push_word(kind, sys, pp5, ap, susp);
    endtask

    function automatic int clip_len(input int len, input int goal);
        int room;
        room = goal - words_queued;
        if (len > room)
            len = room;
        if (len > 400)
            len = 400;
        return (len < 1) ? 1 : len;
    endfunction

    // well-formed power sequences with random content, plus some plain noise
    task automatic queue_bursts(input int n);
        int goal;
        int pick;
        int len;
        int d;
        int p;
        goal = words_queued + n;
        d    = (step_dly_cfg == 0) ? 1 : step_dly_cfg;
        p    = (rst_pulse_cfg == 0) ? 1 : rst_pulse_cfg;
        while (words_queued < goal) begin
            pick = $urandom_range(99);
            if (pick < 25) begin
                // press and hold every supply good: g3 all the way to s0
                push_word(KIND_BUTTON, 1, 1, 1, 1);
                len = clip_len(10 * d + p + 6 + $urandom_range(15), goal);
                repeat (len) push_tick(1, 1, 1, 1);
            end else if (pick < 45) begin
                // dwell wherever we are, suspend request now and then
                repeat ($urandom_range(40, 5)) push_tick(1, 1, 1, $urandom_range(99) < 80);
            end else if (pick < 60) begin
                // lose ap power with suspend requested, sit in s3, then resume
                repeat ($urandom_range(20, 2)) push_tick(1, 1, 0, 0);
                len = clip_len(4 * d + p + 4, goal);
                repeat (len) push_tick(1, 1, 1, 1);
            end else if (pick < 75) begin
                // shutdown request followed by a few random ticks
                push_word($urandom_range(1) ? KIND_FORCE_OFF : KIND_BUTTON,
                          $urandom_range(1), $urandom_range(1), $urandom_range(1),
                          $urandom_range(1));
                repeat ($urandom_range(12, 4))
                    push_tick($urandom_range(1), $urandom_range(1), $urandom_range(1),
                              $urandom_range(1));
            end else if (pick < 83) begin
                // resume attempt that never sees ap power good
                len = clip_len(4 * d + p + pgood_tmo_cfg + 6, goal);
                repeat (len) push_tick(1, 1, 0, 1);
            end else if (pick < 90) begin
                // power-up attempt with pp5000 missing
                push_word(KIND_BUTTON, 1, 0, 1, 1);
                len = clip_len(6 * d + pgood_tmo_cfg + 6, goal);
                repeat (len) push_tick($urandom_range(1), 0, $urandom_range(1), 1);
            end else begin
                repeat ($urandom_range(30, 5))
                    push_word($urandom_range(3), $urandom_range(1), $urandom_range(1),
                              $urandom_range(1), $urandom_range(1));
            end
        end
    endtask

    task automatic wait_idle();
        while (pending_words_q.size() != 0 || s_axis_tvalid || expected_status_q.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_STEP_DELAY:  step_dly_cfg  = val[7:0];
            CFG_RESET_PULSE: rst_pulse_cfg = val[7:0];
            CFG_PGOOD_TMO:   pgood_tmo_cfg = val[15:0];
            CFG_USB_A_ON:    usb_a_cfg     = val[0];
            default: ;
        endcase
    endtask

    task automatic write_all(input int dly, input int pulse, input int tmo, input int usb);
        write_reg(CFG_STEP_DELAY, CFG_W'(dly));
        write_reg(CFG_RESET_PULSE, CFG_W'(pulse));
        write_reg(CFG_PGOOD_TMO, CFG_W'(tmo));
        write_reg(CFG_USB_A_ON, CFG_W'(usb));
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
        settings_run++;
    endtask

    // one random phase: sender drains first, then new settings and pacing
    task automatic run_phase(input int dly, input int pulse, input int tmo, input int usb,
                             input int send_pct, input int recv_pct, input int n,
                             input int hold);
        wait_idle();
        write_all(dly, pulse, tmo, usb);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_bursts(n);
        if (hold != 0)
            hold_left = hold;
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed walk with the shortest delays: g3 -> s0 and back, every event kind
        write_all(0, 1, 2, 1);
        push_word(KIND_TICK, 0, 0, 0, 0);        // idle g3, nothing good
        push_word(KIND_BUTTON, 1, 1, 1, 1);      // wake from g3
        push_word(KIND_BUTTON, 1, 1, 1, 1);      // ignored in g3s5
        push_word(KIND_BUTTON, 1, 1, 1, 1);      // ignored in s5
        repeat (7) push_word(KIND_TICK, 1, 1, 1, 0);   // power-up groups, zero delay acts as one
        push_word(KIND_TICK, 1, 1, 1, 0);        // s3, suspend still requested
        push_word(KIND_TICK, 1, 1, 1, 1);        // suspend released
        repeat (4) push_word(KIND_TICK, 1, 1, 1, 1);
        push_word(KIND_WARM_RST, 1, 1, 1, 1);    // warm reset on the reset hold group
        push_word(KIND_TICK, 1, 1, 1, 1);        // last group, into s0
        push_word(KIND_WARM_RST, 1, 1, 1, 1);    // warm reset while in s0
        push_word(KIND_FORCE_OFF, 1, 1, 1, 1);   // forced shutdown from s0
        push_word(KIND_TICK, 1, 1, 1, 1);
        push_word(KIND_TICK, 1, 1, 1, 1);
        push_word(KIND_TICK, 1, 0, 1, 1);        // pp5000 dropped on the way down
        push_word(KIND_TICK, 0, 0, 0, 0);
        push_word(KIND_TICK, 0, 0, 0, 0);        // back to g3 levels
        push_word(KIND_FORCE_OFF, 0, 0, 0, 0);   // forced shutdown while already in g3
        wait_idle();

        run_phase(2, 10, 1000, 0, 0, 0, 300, 0);        // reset-like values, no idling
        run_phase(1, 3, 5, 1, 51, 0, 350, 0);           // short timeout, idle sender
        run_phase(0, 255, 1, 1, 0, 51, 250, 0);         // longest reset hold, stalling receiver
        run_phase(255, 1, 65535, 0, 27, 27, 150, 0);    // widest step delay and timeout
        run_phase(3, 2, 8, 1, 0, 0, 250, 300);          // receiver held off, input fills up
        run_phase(1, 4, 12, 1, 27, 27, 450, 0);

        wait_idle();
        repeat (8) @(posedge i_clk);

        $display("checked %0d result words under %0d register settings", words_checked,
                 settings_run);
        $display("seen: %0d resumes to s0, %0d power-good timeouts, %0d warm resets",
                 resumes, pgood_faults, warm_resets);
        if (mismatches == 0) begin
            $display("[soc_power_rail_sequencer_unit] OK");
        end else begin
            $display("[soc_power_rail_sequencer_unit] ERROR");
        end
        $finish;
    end

    // hard stop well past the slowest correct run
    initial begin : watchdog
        #3000000;
        $display("timeout with %0d words still pending", expected_status_q.size());
        $display("[soc_power_rail_sequencer_unit] ERROR");
        $finish;
    end

endmodule
